### design/cal_adv_pkg.sv
// Shared types, constants and calendar helpers for the calendar advance block.
package cal_adv_pkg;

  // Stream payload widths (fields packed from bit 0 up, padded to bytes)
  localparam int IN_FIELDS_W  = 70;
  localparam int IN_DATA_W    = 72;
  localparam int OUT_FIELDS_W = 38;
  localparam int OUT_DATA_W   = 40;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int ADD_W    = 32;

  // Arithmetic widths
  localparam int TOD_W      = 17;  // seconds of the start time of day, up to 115443
  localparam int TOTAL_W    = 33;  // time of day plus added seconds
  localparam int REM_W      = 17;  // remainder after whole days, below 86400
  localparam int HOUR_REM_W = 12;  // remainder after whole hours, below 3600
  localparam int DAYS_W     = 17;  // whole days, up to 49711
  localparam int QUO_W      = 17;  // widest quotient, the whole days
  localparam int STEP_W     = 6;   // days to cross into the next month, up to 32

  // Division by constants: drop the divisor's power of two, multiply by a rounded-up
  // reciprocal of the odd part and keep the bits above the shift.
  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15; exact over the dividend ranges here.
  localparam int DAY_PRE    = 7;
  localparam int HOUR_PRE   = 4;
  localparam int MIN_PRE    = 2;
  localparam int DAY_SHIFT  = 36;
  localparam int HOUR_SHIFT = 20;
  localparam int MIN_SHIFT  = 14;
  localparam int MUL_A_W    = TOTAL_W - DAY_PRE;
  localparam int RECIP_W    = 27;
  localparam int PROD_W     = MUL_A_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_DAY  = RECIP_W'(101806633);
  localparam logic [RECIP_W-1:0] RECIP_HOUR = RECIP_W'(4661);
  localparam logic [RECIP_W-1:0] RECIP_MIN  = RECIP_W'(1093);

  localparam logic [REM_W-1:0]   SECS_PER_DAY  = REM_W'(86400);
  localparam logic [REM_W-1:0]   SECS_PER_HOUR = REM_W'(3600);
  localparam logic [REM_W-1:0]   SECS_PER_MIN  = REM_W'(60);
  localparam logic [MONTH_W-1:0] MONTH_FEB     = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC     = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] MONTH_JAN     = MONTH_W'(1);
  localparam logic [DAY_W-1:0]   DAY_FIRST     = DAY_W'(1);

  // Inverse of 25 modulo 2^12, and the largest residue that marks a multiple of 25
  localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(3113);
  localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(163);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOD,
    ST_TOTAL,
    ST_DIVIDE,
    ST_DIV_END,
    ST_WALK,
    ST_OUT
  } state_t;

  // Divisor selection for the shared divider
  typedef enum logic [1:0] {
    SEL_DAY,
    SEL_HOUR,
    SEL_MIN
  } sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic calc_tod;
    logic calc_total;
    logic div_step;
    logic div_done;
    sel_t sel;
    logic walk_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic days_zero;
    logic out_free;
  } status_t;

  // Full Gregorian leap rule on a 12-bit year; divisibility by 25 via the modular inverse
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    logic                div4;
    logic                div16;
    prod  = y * INV25;
    div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
    div4  = (y[1:0] == 2'b00);
    div16 = (y[3:0] == 4'b0000);
    return (div4 && !div25) || (div16 && div25);
  endfunction

  // Month length; months outside 1..12 have length 0
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

### design/cal_adv_dp.sv
// Datapath: input capture, seconds sum, constant-divisor split, month walk, output register.
module cal_adv_dp import cal_adv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_valid,
  input  logic                  out_ready
);

  // Calendar and time registers
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;
  logic [ADD_W-1:0]    add_secs;
  logic [TOD_W-1:0]    tod;
  logic [DAYS_W-1:0]   days;
  logic                leap;

  // Divider registers: current dividend and quotient
  logic [TOTAL_W-1:0]  dividend;
  logic [QUO_W-1:0]    quo;

  // Divider: reciprocal multiply for the quotient, multiply back for the remainder
  logic [REM_W-1:0]     divisor;
  logic [MUL_A_W-1:0]   mul_a;
  logic [RECIP_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [QUO_W-1:0]     quo_calc;
  logic [2*REM_W-1:0]   back;
  logic [TOTAL_W-1:0]   rem_full;

  always_comb begin
    unique case (cmd.sel)
      SEL_DAY: begin
        divisor = SECS_PER_DAY;
        mul_a   = dividend[TOTAL_W-1:DAY_PRE];
        mul_b   = RECIP_DAY;
      end
      SEL_HOUR: begin
        divisor = SECS_PER_HOUR;
        mul_a   = MUL_A_W'(dividend[REM_W-1:HOUR_PRE]);
        mul_b   = RECIP_HOUR;
      end
      default: begin
        divisor = SECS_PER_MIN;
        mul_a   = MUL_A_W'(dividend[HOUR_REM_W-1:MIN_PRE]);
        mul_b   = RECIP_MIN;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    unique case (cmd.sel)
      SEL_DAY:  quo_calc = prod[DAY_SHIFT +: QUO_W];
      SEL_HOUR: quo_calc = prod[HOUR_SHIFT +: QUO_W];
      default:  quo_calc = prod[MIN_SHIFT +: QUO_W];
    endcase
    back     = (2*REM_W)'(quo) * (2*REM_W)'(divisor);
    rem_full = dividend - back[TOTAL_W-1:0];
  end

  // Month walk: days needed to reach the first of the next month
  logic [DAY_W-1:0]  len;
  logic [STEP_W-1:0] to_next;
  logic              jump;

  always_comb begin
    len     = month_len(month, leap);
    to_next = (day >= len) ? STEP_W'(1) : (STEP_W'(len) - STEP_W'(day) + STEP_W'(1));
    jump    = (days >= DAYS_W'(to_next));
  end

  // Leap flag is registered from the year, so it follows it in the next cycle; the year only changes into January
  always_ff @(posedge clk) begin
    leap <= is_leap(year);
  end

  // Main datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      {add_secs, second, minute, hour, day, month, year} <= in_data[IN_FIELDS_W-1:0];
    end else if (cmd.calc_tod) begin
      tod <= TOD_W'(second) + TOD_W'(minute) * TOD_W'(SECS_PER_MIN)
           + TOD_W'(hour) * TOD_W'(SECS_PER_HOUR);
    end else if (cmd.calc_total) begin
      dividend <= TOTAL_W'(tod) + TOTAL_W'(add_secs);
    end else if (cmd.div_step) begin
      quo <= quo_calc;
    end else if (cmd.div_done) begin
      // Take the result and reload the remainder as the next dividend
      case (cmd.sel)
        SEL_DAY:  days <= quo[DAYS_W-1:0];
        SEL_HOUR: hour <= quo[HOUR_W-1:0];
        default: begin
          minute <= quo[MINUTE_W-1:0];
          second <= rem_full[SECOND_W-1:0];
        end
      endcase
      dividend <= TOTAL_W'(rem_full[REM_W-1:0]);
    end else if (cmd.walk_step) begin
      if (jump) begin
        days <= days - DAYS_W'(to_next);
        day  <= DAY_FIRST;
        if (month >= MONTH_DEC) begin
          month <= MONTH_JAN;
          year  <= year + YEAR_W'(1);
        end else begin
          month <= month + MONTH_W'(1);
        end
      end else begin
        day  <= day + days[DAY_W-1:0];
        days <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {(OUT_DATA_W - OUT_FIELDS_W)'(0), second, minute, hour, day, month, year};
    end
  end

  assign status.days_zero = (days == '0);
  assign status.out_free  = !out_valid || out_ready;

endmodule

### design/cal_adv_ctrl.sv
// Controller: sequences input capture, the seconds sum, three divisions, the month walk and the output load.
module cal_adv_ctrl import cal_adv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  sel_t   sel, sel_next;

  // State and divisor selection
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= SEL_DAY;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_TOD;
        end
      end
      ST_TOD: begin
        cmd.calc_tod = 1'b1;
        state_next   = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd.calc_total = 1'b1;
        sel_next       = SEL_DAY;
        state_next     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        state_next   = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.div_done = 1'b1;
        unique case (sel)
          SEL_DAY: begin
            sel_next   = SEL_HOUR;
            state_next = ST_DIVIDE;
          end
          SEL_HOUR: begin
            sel_next   = SEL_MIN;
            state_next = ST_DIVIDE;
          end
          default: begin
            state_next = ST_WALK;
          end
        endcase
      end
      ST_WALK: begin
        if (status.days_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/calendar_advance_by_seconds_core.sv
// Calendar advance by seconds: adds a seconds count to a date and time of day.
//
// Input stream (s_*): one transaction carries the start date, time of day and
// the seconds to add. Output stream (m_*): one transaction per input carries
// the resulting date and time.
// Sequence: after the accepting edge, the time of day and then the seconds
// sum are formed, three divisions by constants (86400, 3600, 60) each use a
// reciprocal multiply, then a multiply back for the remainder, a walk moves
// one calendar month per cycle, a last walk step adds any remaining days, the
// day count is seen at zero and the output register is loaded once it is free.
// The walk crosses up to about 1640 month boundaries for the largest seconds
// count. One item is worked on at a time.
// s_tready is high only while the controller is idle. The result sits in an
// output register, so the next item is taken while it waits: a stall on
// m_tready holds m_tvalid and m_tdata, and only blocks the following result.
// Reset (rst, synchronous) returns the controller to idle and drops m_tvalid.
module calendar_advance_by_seconds_core import cal_adv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // start_year, start_month, start_day, start_hour, start_minute, start_second, add_seconds
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // end_year, end_month, end_day, end_hour, end_minute, end_second
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  cal_adv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and calendar registers
  cal_adv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule
